@@ sv/binned_mean_square_histogram_macros.svh @@
// Assertion helpers shared by the histogram RTL.
`ifndef BINNED_MEAN_SQUARE_HISTOGRAM_MACROS_SVH
`define BINNED_MEAN_SQUARE_HISTOGRAM_MACROS_SVH

`ifndef SYNTHESIS

// ante implies cons in the same cycle
`define BMSH_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error(msg);

// ante implies cons in the next cycle
`define BMSH_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error(msg);

`else

`define BMSH_ASSERT_IMP(lbl, ck, rn, ante, cons, msg)
`define BMSH_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg)

`endif

`endif

@@ sv/bmsh_pkg.sv @@
package bmsh_pkg;

  localparam int NUM_BINS_DEF = 4096;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_RECIP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNSYM     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_THR  = 2'd3;

  localparam logic [31:0] BIN_WIDTH_RST = 32'h0001_0000;
  localparam logic [31:0] BIN_RECIP_RST = 32'h0001_0000;
  localparam logic [15:0] ZERO_THR_RST  = 16'd13;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [2:0] ST_ADDED = 3'd0;
  localparam logic [2:0] ST_SKIP  = 3'd1;
  localparam logic [2:0] ST_BELOW = 3'd2;
  localparam logic [2:0] ST_ABOVE = 3'd3;
  localparam logic [2:0] ST_READ  = 3'd4;

  typedef struct packed {
    logic               opcode;
    logic signed [31:0] x_value;
    logic signed [23:0] y_value;
    logic signed [11:0] read_bin;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] bin_center;
    logic [47:0]        mean_square;
    logic [47:0]        error_bar;
    logic [31:0]        bin_count;
    logic [11:0]        lowest_used;
    logic [11:0]        highest_used;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic chk;
    logic rd;
    logic sel2;
    logic wr;
    logic div1_start;
    logic div2_start;
    logic take_mean;
    logic out_load;
    logic clr;
  } dp_cmd_t;

  typedef struct packed {
    logic is_read;
    logic unsym;
    logic fail;
    logic empty;
    logic div_busy;
    logic sqrt_busy;
    logic clr_done;
  } dp_sts_t;

endpackage

@@ sv/bmsh_div.sv @@
module bmsh_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic [63:0] quotient
);

  logic [63:0] quo_r;
  logic [31:0] rem_r;
  logic [31:0] dsr_r;
  logic [6:0]  cnt_r;
  logic        busy_r;
  logic [32:0] trial;
  logic [32:0] diff;
  logic        ge;

  // one quotient bit per cycle, restoring
  assign trial = {rem_r, quo_r[63]};
  assign ge    = trial >= {1'b0, dsr_r};
  assign diff  = trial - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 7'd0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 7'd64;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= 32'd0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[62:0], ge};
      rem_r <= ge ? diff[31:0] : trial[31:0];
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

@@ sv/bmsh_sqrt.sv @@
module bmsh_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        busy,
  output logic [31:0] root
);

  logic [63:0] v_r;
  logic [63:0] res_r;
  logic [4:0]  k_r;
  logic        busy_r;
  logic [63:0] bitv;
  logic [63:0] sum;
  logic        ge;

  // test bit 4^k, k from 31 down to 0
  assign bitv = 64'd1 << {k_r, 1'b0};
  assign sum  = res_r + bitv;
  assign ge   = v_r >= sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      k_r    <= 5'd0;
    end else if (start) begin
      busy_r <= 1'b1;
      k_r    <= 5'd31;
    end else if (busy_r) begin
      k_r <= k_r - 5'd1;
      if (k_r == 5'd0) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r   <= radicand;
      res_r <= 64'd0;
    end else if (busy_r) begin
      if (ge) begin
        v_r   <= v_r - sum;
        res_r <= (res_r >> 1) + bitv;
      end else begin
        res_r <= res_r >> 1;
      end
    end
  end

  assign busy = busy_r;
  assign root = res_r[31:0];

endmodule

@@ sv/bmsh_dp.sv @@
`include "binned_mean_square_histogram_macros.svh"

module bmsh_dp #(
  parameter int NUM_BINS = bmsh_pkg::NUM_BINS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [bmsh_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [31:0]                         cfg_data,
  input  bmsh_pkg::in_item_t                  in_data,
  input  bmsh_pkg::dp_cmd_t                   cmd,
  output bmsh_pkg::dp_sts_t                   sts,
  output bmsh_pkg::out_item_t                 out_data
);

  import bmsh_pkg::*;

  localparam int IDX_W = $clog2(NUM_BINS);
  localparam int RW    = ((IDX_W > 12) ? IDX_W : 12) + 2;
  localparam logic [33:0] HALF_W = 34'(NUM_BINS / 2);
  localparam logic [33:0] NUM_W  = 34'(NUM_BINS);

  logic [31:0] width_r;
  logic [31:0] recip_r;
  logic        unsym_r;
  logic [15:0] thr_r;

  in_item_t           in_r;
  logic [63:0]        prod_r;
  logic [47:0]        sq_r;
  logic signed [45:0] cen_r;
  logic               skip_r;
  logic               neg_r;
  logic [2:0]         status_r;
  logic [IDX_W-1:0]   b1_r;
  logic [IDX_W-1:0]   b2_r;
  logic [95:0]        mem [NUM_BINS];
  logic [95:0]        rdata_r;
  logic [IDX_W-1:0]   lo_r;
  logic [IDX_W-1:0]   hi_r;
  logic [IDX_W-1:0]   clr_cnt_r;
  logic [47:0]        mean_r;
  out_item_t          out_r;

  logic [31:0]        xu;
  logic [31:0]        ax;
  logic [23:0]        yu;
  logic [23:0]        ay;
  logic signed [12:0] odd;
  logic signed [32:0] ws;
  logic [33:0]        q34;
  logic [33:0]        pos;
  logic [33:0]        neg;
  logic               pos_hi;
  logic               neg_lo;
  logic signed [RW-1:0] ridx;
  logic               ridx_hi;
  logic               ridx_lo;
  logic [2:0]         chk_status;
  logic [IDX_W-1:0]   chk_b1;
  logic [IDX_W-1:0]   wa;
  logic [31:0]        cnt_old;
  logic [63:0]        sum_old;
  logic [31:0]        cnt_new;
  logic [64:0]        sum_add;
  logic [63:0]        sum_new;
  logic               div_start;
  logic [63:0]        div_dvd;
  logic [31:0]        div_dsr;
  logic               div_busy;
  logic [63:0]        quo;
  logic [47:0]        mean_sat;
  logic [32:0]        n1;
  logic               sqrt_busy;
  logic [31:0]        root;
  logic signed [45:0] cen_sh;
  logic signed [31:0] cen_sat;
  logic               read_ok;
  logic               empty;
  logic [31:0]        lo32;
  logic [31:0]        hi32;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= BIN_WIDTH_RST;
      recip_r <= BIN_RECIP_RST;
      unsym_r <= 1'b0;
      thr_r   <= ZERO_THR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BIN_WIDTH: width_r <= cfg_data;
        CFG_BIN_RECIP: recip_r <= cfg_data;
        CFG_UNSYM:     unsym_r <= cfg_data[0];
        CFG_ZERO_THR:  thr_r   <= cfg_data[15:0];
      endcase
    end
  end

  // multiply stage
  assign xu  = in_r.x_value;
  assign ax  = xu[31] ? (32'd0 - xu) : xu;
  assign yu  = in_r.y_value;
  assign ay  = yu[23] ? (24'd0 - yu) : yu;
  assign odd = {in_r.read_bin, 1'b1};
  assign ws  = {1'b0, width_r};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_r <= in_data;
    end
    if (cmd.mul) begin
      prod_r <= ax * recip_r;
      sq_r   <= ay * ay;
      cen_r  <= odd * ws;
      skip_r <= ax <= {16'd0, thr_r};
      neg_r  <= xu[31];
    end
  end

  // bin index and range check: floor of a negative product rounds away
  assign q34    = {2'b00, prod_r[63:32]};
  assign pos    = HALF_W + q34;
  assign neg    = HALF_W - q34 - {33'd0, |prod_r[31:0]};
  assign pos_hi = pos >= NUM_W;
  assign neg_lo = neg[33];

  assign ridx    = {{(RW-12){in_r.read_bin[11]}}, in_r.read_bin} + RW'(NUM_BINS / 2);
  assign ridx_lo = ridx[RW-1];
  assign ridx_hi = !ridx[RW-1] && ($unsigned(ridx) >= RW'(NUM_BINS));

  always_comb begin
    if (in_r.opcode == OP_READ) begin
      chk_status = ridx_hi ? ST_ABOVE : (ridx_lo ? ST_BELOW : ST_READ);
    end else if (skip_r) begin
      chk_status = ST_SKIP;
    end else if (unsym_r) begin
      if (neg_r) begin
        chk_status = neg_lo ? ST_BELOW : ST_ADDED;
      end else begin
        chk_status = pos_hi ? ST_ABOVE : ST_ADDED;
      end
    end else begin
      chk_status = pos_hi ? ST_ABOVE : (neg_lo ? ST_BELOW : ST_ADDED);
    end
  end

  always_comb begin
    if (in_r.opcode == OP_READ) begin
      chk_b1 = ridx[IDX_W-1:0];
    end else if (unsym_r && neg_r) begin
      chk_b1 = neg[IDX_W-1:0];
    end else begin
      chk_b1 = pos[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.chk) begin
      status_r <= chk_status;
      b1_r     <= chk_b1;
      b2_r     <= neg[IDX_W-1:0];
    end
  end

  // bin memory: count in the low word, sum of squares above
  assign wa      = cmd.sel2 ? b2_r : b1_r;
  assign cnt_old = rdata_r[31:0];
  assign sum_old = rdata_r[95:32];
  assign cnt_new = (&cnt_old) ? cnt_old : (cnt_old + 32'd1);
  assign sum_add = {1'b0, sum_old} + {17'd0, sq_r};
  assign sum_new = sum_add[64] ? '1 : sum_add[63:0];

  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      mem[clr_cnt_r] <= '0;
    end else if (cmd.wr) begin
      mem[wa] <= {sum_new, cnt_new};
    end
    if (cmd.rd) begin
      rdata_r <= mem[wa];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      lo_r      <= IDX_W'(NUM_BINS - 1);
      hi_r      <= '0;
    end else begin
      if (cmd.clr) begin
        clr_cnt_r <= clr_cnt_r + IDX_W'(1);
      end
      if (cmd.wr) begin
        if (wa > hi_r) begin
          hi_r <= wa;
        end
        if (wa < lo_r) begin
          lo_r <= wa;
        end
      end
    end
  end

  // shared divider: sum / count, then (mean << 15) / root
  assign n1        = {1'b0, cnt_old} + 33'd1;
  assign mean_sat  = (|quo[63:48]) ? '1 : quo[47:0];
  assign div_start = cmd.div1_start || cmd.div2_start;
  assign div_dvd   = cmd.div2_start ? {1'b0, mean_sat, 15'd0} : sum_old;
  assign div_dsr   = cmd.div2_start ? root : cnt_old;

  bmsh_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .busy     (div_busy),
    .quotient (quo)
  );

  bmsh_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div1_start),
    .radicand ({1'b0, n1, 30'd0}),
    .busy     (sqrt_busy),
    .root     (root)
  );

  always_ff @(posedge clk) begin
    if (cmd.take_mean) begin
      mean_r <= mean_sat;
    end
  end

  // result
  assign cen_sh  = cen_r >>> 1;
  assign read_ok = status_r == ST_READ;
  assign empty   = cnt_old == 32'd0;
  assign lo32    = 32'(lo_r);
  assign hi32    = 32'(hi_r);

  always_comb begin
    if (cen_sh > $signed(46'h0000_7FFF_FFFF)) begin
      cen_sat = 32'sh7FFF_FFFF;
    end else if (cen_sh < $signed(46'h3FFF_8000_0000)) begin
      cen_sat = 32'sh8000_0000;
    end else begin
      cen_sat = cen_sh[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.status       <= status_r;
      out_r.bin_center   <= read_ok ? cen_sat : 32'sd0;
      out_r.mean_square  <= (read_ok && !empty) ? mean_r : 48'd0;
      out_r.error_bar    <= (read_ok && !empty) ? quo[47:0] : 48'd0;
      out_r.bin_count    <= read_ok ? cnt_old : 32'd0;
      out_r.lowest_used  <= lo32[11:0];
      out_r.highest_used <= hi32[11:0];
    end
  end

  assign out_data = out_r;

  assign sts.is_read   = in_r.opcode == OP_READ;
  assign sts.unsym     = unsym_r;
  assign sts.fail      = (chk_status != ST_ADDED) && (chk_status != ST_READ);
  assign sts.empty     = empty;
  assign sts.div_busy  = div_busy;
  assign sts.sqrt_busy = sqrt_busy;
  assign sts.clr_done  = clr_cnt_r == IDX_W'(NUM_BINS - 1);

  `BMSH_ASSERT_NEXT(a_lo_le_hi, clk, rst_n, cmd.wr, lo_r <= hi_r, "used-bin bounds crossed")

endmodule

@@ sv/bmsh_ctrl.sv @@
`include "binned_mean_square_histogram_macros.svh"

module bmsh_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  bmsh_pkg::dp_sts_t   sts,
  output bmsh_pkg::dp_cmd_t   cmd
);

  import bmsh_pkg::*;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_MUL  = 4'd2;
  localparam logic [3:0] S_CHK  = 4'd3;
  localparam logic [3:0] S_RD   = 4'd4;
  localparam logic [3:0] S_UPD  = 4'd5;
  localparam logic [3:0] S_DIV1 = 4'd6;
  localparam logic [3:0] S_DIV2 = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  logic [3:0] state_r;
  logic [3:0] state_nxt;
  logic       sel2_r;
  logic       sel2_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    sel2_nxt      = sel2_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_CLR: begin
        cmd.clr = 1'b1;
        if (sts.clr_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          sel2_nxt  = 1'b0;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        cmd.chk   = 1'b1;
        state_nxt = sts.fail ? S_OUT : S_RD;
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        if (sts.is_read) begin
          if (sts.empty) begin
            state_nxt = S_OUT;
          end else begin
            cmd.div1_start = 1'b1;
            state_nxt      = S_DIV1;
          end
        end else begin
          cmd.wr = 1'b1;
          // symmetric mode: go back for the mirrored bin
          if (!sts.unsym && !sel2_r) begin
            sel2_nxt  = 1'b1;
            state_nxt = S_RD;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_DIV1: begin
        if (!sts.div_busy && !sts.sqrt_busy) begin
          cmd.take_mean  = 1'b1;
          cmd.div2_start = 1'b1;
          state_nxt      = S_DIV2;
        end
      end
      S_DIV2: begin
        if (!sts.div_busy) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    cmd.sel2 = sel2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      sel2_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sel2_r      <= sel2_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;

  `BMSH_ASSERT_IMP(a_wr_sample, clk, rst_n, cmd.wr, !sts.is_read, "bin write on a read item")
  `BMSH_ASSERT_IMP(a_div2_free, clk, rst_n, cmd.div2_start, !sts.div_busy && !sts.sqrt_busy, "second divide started early")
  `BMSH_ASSERT_NEXT(a_div_runs, clk, rst_n, cmd.div1_start, sts.div_busy && sts.sqrt_busy, "divide or root did not start")

endmodule

@@ sv/binned_mean_square_histogram.sv @@
// Binned mean-square histogram. Sample items (opcode 0) add y*y into the bin of x (and, in
// symmetric mode, also into the mirrored bin of -x); read items (opcode 1) return one bin's
// center, mean square, error bar and count. Bins live in one single-port memory, so a sample
// passes from acceptance through multiply, check and one read-modify-write per bin (two in
// symmetric mode) to the result; skipped and out-of-range samples go from the check straight
// to the result. A read of a non-empty bin runs a 64-bit bit-serial divider twice (sum/count,
// then mean/root) with the bit-serial square root overlapping the first pass; a read of an
// empty bin skips the divides and an out-of-range read goes from the check to the result.
// Result back-pressure can hold the block in its output step. After reset the block clears
// the bin memory, one entry per cycle, before taking any item; configuration writes are taken
// at all times and must only be made while the block is idle.
module binned_mean_square_histogram #(
  parameter int NUM_BINS = bmsh_pkg::NUM_BINS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bmsh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  bmsh_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output bmsh_pkg::out_item_t            out_data
);

  import bmsh_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  bmsh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bmsh_dp #(
    .NUM_BINS (NUM_BINS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule

@@ bench/tb_binned_mean_square_histogram.sv @@
module tb_binned_mean_square_histogram;
  timeunit 1ns;
  timeprecision 1ps;
  import bmsh_pkg::*;

  localparam int NBINS = NUM_BINS_DEF;
  localparam int STALL_LIMIT = 20000;

  logic clk;
  logic rst_n;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_data;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;

  binned_mean_square_histogram u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // shadow of the block's configuration and bin memory
  logic [31:0] width_q;
  logic [31:0] recip_q;
  logic unsym_q;
  logic [15:0] thr_q;
  logic [31:0] count_mem [NBINS];
  logic [63:0] sum_mem [NBINS];
  int unsigned low_bin;
  int unsigned high_bin;

  out_item_t expected_q[$];
  int errors;
  int idle_cycles;
  bit done;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint floor_div2k(longint p, int k);
    longint mag;
    if (p >= 0) return p >>> k;
    mag = -p;
    mag = (mag + ((64'sd1 <<< k) - 1)) >>> k;
    return -mag;
  endfunction

  function automatic longint bin_index(longint x);
    return floor_div2k(x * longint'({32'd0, recip_q}), 32) + NBINS / 2;
  endfunction

  function automatic logic [2:0] range_code(longint idx);
    if (idx >= NBINS) return ST_ABOVE;
    if (idx < 0) return ST_BELOW;
    return ST_ADDED;
  endfunction

  function automatic void accumulate(int unsigned idx, logic [63:0] sq);
    if (count_mem[idx] != 32'hFFFF_FFFF) count_mem[idx] = count_mem[idx] + 1;
    if (sum_mem[idx] > ~64'd0 - sq) sum_mem[idx] = ~64'd0;
    else sum_mem[idx] = sum_mem[idx] + sq;
    if (idx > high_bin) high_bin = idx;
    if (idx < low_bin) low_bin = idx;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic out_item_t histogram_result(in_item_t it);
    out_item_t r;
    longint x, ax, b1, b2, idx, c, rb;
    logic [63:0] ay, sq, mean, s;
    logic [31:0] n;
    r = '0;
    if (it.opcode == OP_ADD) begin
      x = longint'(it.x_value);
      ay = (it.y_value < 0) ? 64'(-longint'(it.y_value)) : 64'(longint'(it.y_value));
      sq = ay * ay;
      ax = (x < 0) ? -x : x;
      if (!unsym_q) x = ax;
      if (ax <= longint'({48'd0, thr_q})) begin
        r.status = ST_SKIP;
      end else begin
        b1 = bin_index(x);
        b2 = 0;
        r.status = range_code(b1);
        if (r.status == ST_ADDED && !unsym_q) begin
          b2 = bin_index(-x);
          r.status = range_code(b2);
        end
        if (r.status == ST_ADDED) begin
          accumulate(int'(b1), sq);
          if (!unsym_q) accumulate(int'(b2), sq);
        end
      end
    end else begin
      rb = longint'(it.read_bin);
      idx = rb + NBINS / 2;
      r.status = range_code(idx);
      if (r.status == ST_ADDED) begin
        c = floor_div2k((2 * rb + 1) * longint'({32'd0, width_q}), 1);
        if (c > 64'sd2147483647) c = 64'sd2147483647;
        if (c < -64'sd2147483648) c = -64'sd2147483648;
        n = count_mem[idx];
        r.status = ST_READ;
        r.bin_center = c[31:0];
        r.bin_count = n;
        if (n != 0) begin
          mean = sum_mem[idx] / {32'd0, n};
          if (mean > 64'hFFFF_FFFF_FFFF) mean = 64'hFFFF_FFFF_FFFF;
          s = int_sqrt(({32'd0, n} + 64'd1) << 30);
          r.mean_square = mean[47:0];
          r.error_bar = 48'((mean << 15) / s);
        end
      end
    end
    r.lowest_used = low_bin[11:0];
    r.highest_used = high_bin[11:0];
    return r;
  endfunction

  // result checker with random back-pressure
  initial begin
    int hold;
    out_item_t exp_item;
    out_ready <= 1'b0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result item status=%0d", out_data.status);
          errors++;
        end else begin
          exp_item = expected_q.pop_front();
          if (out_data.status !== exp_item.status) begin
            $error("status exp %0d got %0d", exp_item.status, out_data.status); errors++;
          end
          if (out_data.bin_center !== exp_item.bin_center) begin
            $error("bin_center exp %0d got %0d", exp_item.bin_center, out_data.bin_center);
            errors++;
          end
          if (out_data.mean_square !== exp_item.mean_square) begin
            $error("mean_square exp %0h got %0h", exp_item.mean_square, out_data.mean_square);
            errors++;
          end
          if (out_data.error_bar !== exp_item.error_bar) begin
            $error("error_bar exp %0h got %0h", exp_item.error_bar, out_data.error_bar);
            errors++;
          end
          if (out_data.bin_count !== exp_item.bin_count) begin
            $error("bin_count exp %0d got %0d", exp_item.bin_count, out_data.bin_count);
            errors++;
          end
          if (out_data.lowest_used !== exp_item.lowest_used) begin
            $error("lowest_used exp %0d got %0d", exp_item.lowest_used, out_data.lowest_used);
            errors++;
          end
          if (out_data.highest_used !== exp_item.highest_used) begin
            $error("highest_used exp %0d got %0d", exp_item.highest_used,
                   out_data.highest_used);
            errors++;
          end
        end
        hold = $urandom_range(0, 4);
      end
      if ($urandom_range(0, 9) < 3) hold = 0;
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog: count cycles with no handshake on any channel; reset clearing counts too
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT && !done) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // valid stays up past the accept edge only when the next item follows at once
  task automatic send_item(in_item_t it);
    int gap;
    gap = $urandom_range(0, 4);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    expected_q.push_back(histogram_result(it));
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_BIN_WIDTH: width_q = val;
      CFG_BIN_RECIP: recip_q = val;
      CFG_UNSYM: unsym_q = val[0];
      default: thr_q = val[15:0];
    endcase
  endtask

  task automatic apply_setup(logic [31:0] w, logic [31:0] rc, logic u, logic [15:0] t);
    drain();
    write_reg(CFG_BIN_WIDTH, w);
    write_reg(CFG_BIN_RECIP, rc);
    write_reg(CFG_UNSYM, {31'd0, u});
    write_reg(CFG_ZERO_THR, {16'd0, t});
    cfg_valid <= 1'b0;
  endtask

  function automatic in_item_t sample_item(logic signed [31:0] x, logic signed [23:0] y);
    in_item_t it;
    it.opcode = OP_ADD;
    it.x_value = x;
    it.y_value = y;
    it.read_bin = 12'($urandom);
    return it;
  endfunction

  function automatic in_item_t read_item(logic signed [11:0] rb);
    in_item_t it;
    it.opcode = OP_READ;
    it.x_value = $urandom;
    it.y_value = 24'($urandom);
    it.read_bin = rb;
    return it;
  endfunction

  task automatic test_directed;
    send_item(sample_item(32'sd0, 24'sd5));
    send_item(sample_item(32'sd13, 24'sd5));
    send_item(sample_item(-32'sd14, -24'sd8388608));
    send_item(sample_item(32'sh7FFF_FFFF, 24'sd8388607));
    send_item(sample_item(32'sh8000_0000, 24'sd1));
    send_item(sample_item(32'sh0001_8000, -24'sd1));
    send_item(read_item(12'sd1));
    send_item(read_item(-12'sd2));
    send_item(read_item(12'sd0));
    send_item(read_item(12'sh7FF));
    send_item(read_item(12'sh800));
    apply_setup(32'h0000_4000, 32'h0004_0000, 1'b1, 16'd0);
    send_item(sample_item(32'sd1, 24'sd100));
    send_item(sample_item(-32'sd1, 24'sd100));
    send_item(sample_item(32'sh01FF_0000, 24'sh7FFFFF));
    send_item(sample_item(32'sh0200_0000, 24'sd3));
    send_item(sample_item(-32'sh0200_0001, 24'sd3));
    send_item(read_item(12'sh7FF));
    send_item(read_item(12'sh800));
    send_item(read_item(-12'sd1));
  endtask

  task automatic test_extreme_configs;
    int i;
    apply_setup(32'hFFFF_FFFF, 32'd1, 1'b0, 16'hFFFF);
    for (i = 0; i < 10; i++) send_item(sample_item($urandom, 24'($urandom)));
    send_item(read_item(12'sh7FF));
    send_item(read_item(12'sh800));
    send_item(read_item(12'sd0));
    apply_setup(32'd1, 32'hFFFF_FFFF, 1'b1, 16'd0);
    for (i = 0; i < 10; i++) send_item(sample_item(32'($urandom_range(0, 3)) - 2,
                                                 24'($urandom)));
    send_item(read_item(-12'sd1));
    send_item(read_item(12'sd1));
  endtask

  // pile full-scale samples into one bin
  task automatic test_saturation;
    int i;
    apply_setup(32'h0001_0000, 32'h0001_0000, 1'b1, 16'd13);
    for (i = 0; i < 30; i++) send_item(sample_item(32'sh0003_0000, -24'sd8388608));
    send_item(read_item(12'sd3));
  endtask

  task automatic test_random(int n);
    int i, k;
    in_item_t it;
    logic signed [31:0] x;
    for (i = 0; i < n; i++) begin
      if (i % 350 == 0) begin
        k = $urandom_range(0, 3);
        case (k)
          0: apply_setup(32'h0001_0000, 32'h0001_0000, 1'b0, 16'd13);
          1: apply_setup($urandom_range(1, 32'h0008_0000), $urandom_range(1, 32'h0010_0000),
                         1'b1, 16'($urandom));
          2: apply_setup($urandom, $urandom_range(1, 32'h0000_4000), 1'b0,
                         16'($urandom_range(0, 255)));
          default: apply_setup($urandom, $urandom, 1'($urandom), 16'($urandom));
        endcase
      end
      if (i == n / 2) drain();
      if ($urandom_range(0, 3) == 0) begin
        if ($urandom_range(0, 9) == 0) it = read_item(12'($urandom));
        else it = read_item(12'($urandom_range(0, 63)) - 12'sd32);
      end else begin
        case ($urandom_range(0, 3))
          0: x = $urandom;
          1: x = 32'(int'($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
          2: x = 32'(int'($urandom_range(0, 64)) - 32);
          default: x = 32'(int'($urandom_range(0, 32'h1000_0000)) - 32'sh0800_0000);
        endcase
        it = sample_item(x, 24'($urandom));
      end
      send_item(it);
    end
  endtask

  initial begin
    int i;
    errors = 0;
    done = 1'b0;
    rst_n <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_BIN_WIDTH;
    cfg_data <= '0;
    in_valid <= 1'b0;
    in_data <= '0;
    width_q = BIN_WIDTH_RST;
    recip_q = BIN_RECIP_RST;
    unsym_q = 1'b0;
    thr_q = ZERO_THR_RST;
    for (i = 0; i < NBINS; i++) begin
      count_mem[i] = '0;
      sum_mem[i] = '0;
    end
    low_bin = NBINS - 1;
    high_bin = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_extreme_configs();
    test_saturation();
    test_random(1350);
    drain();
    done = 1'b1;
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+sv
sv/bmsh_pkg.sv
sv/bmsh_div.sv
sv/bmsh_sqrt.sv
sv/bmsh_dp.sv
sv/bmsh_ctrl.sv
sv/binned_mean_square_histogram.sv
bench/tb_binned_mean_square_histogram.sv
